[sv/jst_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jst_pkg
// Shared types and codes for the job slot table: request and response items,
// operation and status codes, controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package jst_pkg;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] group_id;
        logic [4:0]         job_id_query;
        logic [1:0]         job_state;
        logic [3:0]         member_count;
        logic [2:0]         member_index;
        logic signed [31:0] member_pid;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [3:0]         slot;
        logic [4:0]         job_id;
        logic signed [31:0] found_group;
        logic [1:0]         found_state;
        logic [3:0]         found_members;
    } rsp_t;

    localparam logic [3:0] K_ADD      = 4'd0;
    localparam logic [3:0] K_SET_MEM  = 4'd1;
    localparam logic [3:0] K_DELETE   = 4'd2;
    localparam logic [3:0] K_BY_GROUP = 4'd3;
    localparam logic [3:0] K_BY_MEM   = 4'd4;
    localparam logic [3:0] K_BY_JOB   = 4'd5;
    localparam logic [3:0] K_FG       = 4'd6;
    localparam logic [3:0] K_STOPPED  = 4'd7;
    localparam logic [3:0] K_RUNNING  = 4'd8;
    localparam logic [3:0] K_ANY      = 4'd9;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_NONE = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_LOW  = 3'd3;
    localparam logic [2:0] ST_BAD  = 3'd4;

    localparam logic [1:0] JS_UNDEF = 2'd0;
    localparam logic [1:0] JS_FG    = 2'd1;
    localparam logic [1:0] JS_BG    = 2'd2;
    localparam logic [1:0] JS_STOP  = 2'd3;

    typedef struct packed {
        logic load;
        logic scan_clr;
        logic slot_inc;
        logic mem_inc;
        logic mem_rd;
        logic set_fail;
        logic set_none;
        logic commit;
        logic top_acc;
    } jst_cmd_t;

    typedef struct packed {
        logic pre_fail;
        logic is_member;
        logic is_delete;
        logic match;
        logic last_slot;
        logic mem_live;
        logic mem_hit;
        logic mem_last;
    } jst_sts_t;

endpackage
`default_nettype wire

[sv/job_slot_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// job_slot_table
// Fixed table of job slots with add, delete, member load and search commands.
// ----------------------------------------------------------------------------
// One item at a time: start is taken while busy is low, and the result shows
// for one cycle with done high; the receiver cannot stall it. Slots are
// scanned one per cycle in a plain search, a delete adds a second pass over
// the slots to find the largest live job id, and a lookup by member reads
// the member memory one entry at a time, a read state then a compare state
// per entry. Rejected items go from the check straight to the result.
// Member ids are not cleared at reset or on delete.
// ----------------------------------------------------------------------------
module job_slot_table #(
    parameter int JOBS    = 16,
    parameter int MEMBERS = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire jst_pkg::req_t  req,
    output logic                done,
    output jst_pkg::rsp_t       rsp
);
    import jst_pkg::*;

    jst_cmd_t cmd;
    jst_sts_t sts;

    jst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .sts   (sts),
        .cmd   (cmd)
    );

    jst_dpath #(
        .JOBS    (JOBS),
        .MEMBERS (MEMBERS)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule
`default_nettype wire

[sv/jst_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jst_ctrl
// Sequencer for the job slot table: checks, slot scan, member scan, update,
// job id rescan after delete, and the one-cycle result strobe.
// ----------------------------------------------------------------------------
module jst_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    output logic                    done,
    input  wire jst_pkg::jst_sts_t  sts,
    output jst_pkg::jst_cmd_t       cmd
);
    import jst_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MSLOT = 3'd3;
    localparam logic [2:0] S_MREAD = 3'd4;
    localparam logic [2:0] S_MCMP  = 3'd5;
    localparam logic [2:0] S_TOP   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.scan_clr = 1'b1;
                if (sts.pre_fail)
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = S_DONE;
                end
                else if (sts.is_member)
                begin
                    state_next = S_MSLOT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.match)
                begin
                    cmd.commit = 1'b1;
                    if (sts.is_delete)
                    begin
                        cmd.scan_clr = 1'b1;
                        state_next   = S_TOP;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (sts.last_slot)
                begin
                    cmd.set_none = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.slot_inc = 1'b1;
                end
            end
            S_MSLOT:
            begin
                if (sts.mem_live)
                begin
                    state_next = S_MREAD;
                end
                else if (sts.last_slot)
                begin
                    cmd.set_none = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.slot_inc = 1'b1;
                end
            end
            S_MREAD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_MCMP;
            end
            S_MCMP:
            begin
                if (sts.mem_hit)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_DONE;
                end
                else if (!sts.mem_last)
                begin
                    cmd.mem_inc = 1'b1;
                    state_next  = S_MREAD;
                end
                else if (sts.last_slot)
                begin
                    cmd.set_none = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.slot_inc = 1'b1;
                    state_next   = S_MSLOT;
                end
            end
            S_TOP:
            begin
                cmd.top_acc = 1'b1;
                if (sts.last_slot)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && cmd.set_none) == 1'b0)
        else $error("hit and miss in one cycle");

endmodule
`default_nettype wire

[sv/jst_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jst_dpath
// Slot table registers, member id memory, scan counters, checks, job id
// counter and result register of the job slot table.
// ----------------------------------------------------------------------------
module jst_dpath #(
    parameter int JOBS    = 16,
    parameter int MEMBERS = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire jst_pkg::req_t      req,
    input  wire jst_pkg::jst_cmd_t  cmd,
    output jst_pkg::jst_sts_t       sts,
    output jst_pkg::rsp_t           rsp
);
    import jst_pkg::*;

    localparam int SW    = $clog2(JOBS);
    localparam int DEPTH = JOBS * MEMBERS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    req_t               req_reg;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;
    logic [SW-1:0]      idx_reg;
    logic [3:0]         mix_reg;
    logic [4:0]         top_reg;
    logic [4:0]         top_next;
    logic [4:0]         njob_reg;
    logic [4:0]         njob_next;
    logic signed [31:0] grp_reg   [JOBS];
    logic [4:0]         jid_reg   [JOBS];
    logic [1:0]         jst_reg   [JOBS];
    logic [3:0]         cnt_reg   [JOBS];
    logic [31:0]        mem       [DEPTH];
    logic [31:0]        mem_q;

    logic signed [31:0] cur_grp;
    logic [4:0]         cur_jid;
    logic [1:0]         cur_st;
    logic [3:0]         cur_cnt;
    logic [3:0]         cur_n;
    logic               grp_low;
    logic               pid_low;
    logic               low;
    logic               bad;
    logic               none_now;
    logic [2:0]         fail_code;
    logic               last;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;
    logic [5:0]         inc_id;

    assign cur_grp = grp_reg[idx_reg];
    assign cur_jid = jid_reg[idx_reg];
    assign cur_st  = jst_reg[idx_reg];
    assign cur_cnt = cnt_reg[idx_reg];
    assign cur_n   = (cur_cnt > 4'(MEMBERS)) ? 4'(MEMBERS) : cur_cnt;
    assign last    = (idx_reg == SW'(JOBS - 1));

    assign grp_low  = (req_reg.group_id == 32'sd0) || req_reg.group_id[31];
    assign pid_low  = (req_reg.member_pid == 32'sd0) || req_reg.member_pid[31];
    assign low      = ((req_reg.kind == K_ADD || req_reg.kind == K_SET_MEM
                        || req_reg.kind == K_DELETE || req_reg.kind == K_BY_GROUP)
                        && grp_low)
                    || (req_reg.kind == K_BY_MEM && pid_low);
    assign bad      = (req_reg.kind == K_ADD && req_reg.member_count > 4'(MEMBERS))
                    || (req_reg.kind == K_SET_MEM
                        && {1'b0, req_reg.member_index} >= 4'(MEMBERS));
    assign none_now = (req_reg.kind == K_BY_JOB && req_reg.job_id_query == 5'd0)
                    || (req_reg.kind > K_ANY);
    assign fail_code = low ? ST_LOW : (bad ? ST_BAD : ST_NONE);

    always_comb
    begin
        sts           = '0;
        sts.pre_fail  = low || bad || none_now;
        sts.is_member = (req_reg.kind == K_BY_MEM);
        sts.is_delete = (req_reg.kind == K_DELETE);
        sts.last_slot = last;
        sts.mem_live  = (cur_grp != 32'sd0) && (mix_reg < cur_n);
        sts.mem_hit   = (mem_q == req_reg.member_pid);
        sts.mem_last  = ({1'b0, mix_reg} + 5'd1) >= {1'b0, cur_n};
        case (req_reg.kind)
            K_ADD:      sts.match = (cur_grp == 32'sd0);
            K_SET_MEM:  sts.match = (cur_grp == req_reg.group_id);
            K_DELETE:   sts.match = (cur_grp == req_reg.group_id);
            K_BY_GROUP: sts.match = (cur_grp == req_reg.group_id);
            K_BY_JOB:   sts.match = (cur_jid == req_reg.job_id_query);
            K_FG:       sts.match = (cur_st == JS_FG);
            K_STOPPED:  sts.match = (cur_st == JS_STOP);
            K_RUNNING:  sts.match = (cur_st == JS_FG) || (cur_st == JS_BG);
            K_ANY:      sts.match = (cur_grp != 32'sd0) && !cur_grp[31];
            default:    sts.match = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            mix_reg <= '0;
            top_reg <= '0;
        end
        else
        begin
            if (cmd.scan_clr)
            begin
                idx_reg <= '0;
                mix_reg <= '0;
                top_reg <= '0;
            end
            else
            begin
                if (cmd.slot_inc || cmd.top_acc)
                begin
                    idx_reg <= idx_reg + SW'(1);
                    mix_reg <= '0;
                end
                else if (cmd.mem_inc)
                begin
                    mix_reg <= mix_reg + 4'd1;
                end
                if (cmd.top_acc)
                begin
                    top_reg <= top_next;
                end
            end
        end
    end

    assign top_next = (cur_jid > top_reg) ? cur_jid : top_reg;
    assign inc_id   = {1'b0, njob_reg} + 6'd1;

    always_comb
    begin
        njob_next = njob_reg;
        if (cmd.commit && req_reg.kind == K_ADD)
        begin
            if (inc_id[4:0] == 5'd0 || inc_id[4:0] > 5'(JOBS))
            begin
                njob_next = 5'd1;
            end
            else
            begin
                njob_next = inc_id[4:0];
            end
        end
        else if (cmd.top_acc && last)
        begin
            njob_next = (top_next == 5'd31) ? 5'd1 : top_next + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            njob_reg <= 5'd1;
            for (int k = 0; k < JOBS; k++)
            begin
                grp_reg[k] <= '0;
                jid_reg[k] <= '0;
                jst_reg[k] <= '0;
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            njob_reg <= njob_next;
            if (cmd.commit && req_reg.kind == K_ADD)
            begin
                grp_reg[idx_reg] <= req_reg.group_id;
                jid_reg[idx_reg] <= njob_reg;
                jst_reg[idx_reg] <= req_reg.job_state;
                cnt_reg[idx_reg] <= req_reg.member_count;
            end
            else if (cmd.commit && req_reg.kind == K_DELETE)
            begin
                grp_reg[idx_reg] <= '0;
                jid_reg[idx_reg] <= '0;
                jst_reg[idx_reg] <= '0;
                cnt_reg[idx_reg] <= '0;
            end
        end
    end

    assign mem_we  = cmd.commit && (req_reg.kind == K_SET_MEM);
    assign wr_addr = AW'(int'(idx_reg) * MEMBERS + int'(req_reg.member_index));
    assign rd_addr = AW'(int'(idx_reg) * MEMBERS + int'(mix_reg));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= req_reg.member_pid;
        end
        if (cmd.mem_rd)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    always_comb
    begin
        rsp_next = rsp_reg;
        if (cmd.set_fail)
        begin
            rsp_next        = '0;
            rsp_next.status = fail_code;
        end
        else if (cmd.set_none)
        begin
            rsp_next        = '0;
            rsp_next.status = (req_reg.kind == K_ADD) ? ST_FULL : ST_NONE;
        end
        else if (cmd.commit)
        begin
            rsp_next.status        = ST_OK;
            rsp_next.slot          = 4'(idx_reg);
            rsp_next.job_id        = (req_reg.kind == K_ADD) ? njob_reg : cur_jid;
            rsp_next.found_group   = (req_reg.kind == K_ADD) ? req_reg.group_id : cur_grp;
            rsp_next.found_state   = (req_reg.kind == K_ADD) ? req_reg.job_state : cur_st;
            rsp_next.found_members = (req_reg.kind == K_ADD) ? req_reg.member_count
                                                             : cur_cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

    a_njob_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        njob_reg != 5'd0)
        else $error("job id counter reached zero");

    a_add_bumps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && req_reg.kind == K_ADD) |=> (njob_reg != $past(njob_reg)))
        else $error("add did not advance job id counter");

    a_fail_no_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_fail |-> !cmd.commit && !mem_we)
        else $error("rejected item changed the table");

endmodule
`default_nettype wire
